// ===== rtl/core/spad_pkg.sv =====
// Shared types, constants and table functions for the star pair angular distance pipeline.
package spad_pkg;

	// Port and field widths
	localparam int COORD_W    = 16;
	localparam int ANGLE_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int FOCAL_W    = 20;

	// Datapath widths
	localparam int NORM_BITS = 30;   // normalized magnitudes stay below 2^30
	localparam int VAL_W     = 31;   // normalized vector component, signed
	localparam int MAG_W     = 30;   // normalized cross/dot magnitude
	localparam int SUMSQ_W   = 62;   // sum of three squared magnitudes
	localparam int ROOT_W    = 31;   // integer square root of SUMSQ_W bits

	// CORDIC
	localparam int CORDIC_STEPS = 32;
	localparam int TURN_BITS    = 40;   // half-turn fraction bits
	localparam int XY_W         = 36;
	localparam int Z_W          = 43;

	// Pipeline depth per unit
	localparam int VEC_STAGES    = 3;
	localparam int PROD_STAGES   = 6;
	localparam int SQRT_STAGES   = ROOT_W;
	localparam int CORDIC_STAGES = CORDIC_STEPS + 3;
	localparam int LATENCY       = VEC_STAGES + PROD_STAGES + SQRT_STAGES + CORDIC_STAGES;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_PITCH_X  = 3'd2,
		REG_PITCH_Y  = 3'd3,
		REG_FOCAL    = 3'd4
	} cfg_reg_t;

	// Camera configuration as seen by the datapath
	typedef struct packed {
		logic [COORD_W-1:0] ctr_col;
		logic [COORD_W-1:0] ctr_row;
		logic [COORD_W-1:0] pitch_x;
		logic [COORD_W-1:0] pitch_y;
		logic [FOCAL_W-1:0] focal_length;
	} cam_cfg_t;

	// Normalized line-of-sight pair (a0,a1,f) and (b0,b1,f)
	typedef struct packed {
		logic signed [VAL_W-1:0] a0;
		logic signed [VAL_W-1:0] a1;
		logic signed [VAL_W-1:0] b0;
		logic signed [VAL_W-1:0] b1;
		logic [NORM_BITS-1:0]    f;
	} los_pair_t;

	// Squared cross magnitude and dot magnitude, into the square root
	typedef struct packed {
		logic [SUMSQ_W-1:0] sumsq;
		logic [MAG_W-1:0]   dmag;
		logic               dot_neg;
	} sumsq_t;

	// Sine and cosine terms, into the CORDIC
	typedef struct packed {
		logic [ROOT_W-1:0] s_term;
		logic [MAG_W-1:0]  dmag;
		logic              dot_neg;
	} sincos_t;

	// atan(2^-i) in Q60 by its power series, i >= 1
	function automatic logic [63:0] atan_pow2_q60(input int unsigned i);
		logic [63:0] acc;
		logic [63:0] t;
		int unsigned sh;
		acc = '0;
		for (int k = 0; k < 31; k++) begin
			sh = i * unsigned'(2 * k + 1);
			if (sh <= 60) begin
				t = (64'd1 << 60) >> sh;
				t = t / 64'(2 * k + 1);
				if ((k & 1) == 1) acc = acc - t;
				else acc = acc + t;
			end
		end
		return acc;
	endfunction

	// atan(1/3) in Q60
	function automatic logic [63:0] atan_third_q60();
		logic [63:0] acc;
		logic [63:0] p;
		logic [63:0] t;
		acc = '0;
		p = (64'd1 << 60) / 64'd3;
		for (int k = 0; k < 40; k++) begin
			if (p != 0) begin
				t = p / 64'(2 * k + 1);
				if ((k & 1) == 1) acc = acc - t;
				else acc = acc + t;
				p = p / 64'd9;
			end
		end
		return acc;
	endfunction

	// CORDIC angle entry: atan(2^-i) in half-turns, 40 fraction bits
	function automatic logic [TURN_BITS-1:0] atan_entry(input int unsigned i);
		logic [63:0] pi_q60;
		logic [63:0] r;
		logic [63:0] q;
		pi_q60 = 64'd4 * (atan_pow2_q60(1) + atan_third_q60());
		r = '0;
		q = '0;
		if (i == 0) begin
			q = 64'd1 << (TURN_BITS - 2);
		end else begin
			r = atan_pow2_q60(i);
			for (int b = 0; b < TURN_BITS; b++) begin
				r = r << 1;
				q = q << 1;
				if (r >= pi_q60) begin
					r = r - pi_q60;
					q = q | 64'd1;
				end
			end
		end
		return q[TURN_BITS-1:0];
	endfunction

endpackage

// ===== rtl/core/star_pair_angular_distance.sv =====
// Top level: angular separation of two star centroids through a pinhole model.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  command  | start / busy           | first_x, first_y, second_x, second_y
//  result   | done (strobe)          | angle_deg
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  A transaction is taken every cycle; busy stays low and cfg_ready stays high.
//  The pipeline has 3 vector stages, 6 product stages, 31 square-root
//  stages (one root bit each) and 35 CORDIC stages (32 rotations each one step).
//  Reset clears the valid chain and restores the camera registers.
//  The result is shown for one cycle on done; the receiver cannot stall.
module star_pair_angular_distance import spad_pkg::*; #(
	parameter int COORD_FRAC_BITS = 4,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COORD_W-1:0]    first_x,
	input  logic [COORD_W-1:0]    first_y,
	input  logic [COORD_W-1:0]    second_x,
	input  logic [COORD_W-1:0]    second_y,
	output logic                  done,
	output logic [ANGLE_W-1:0]    angle_deg,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Camera registers
	cam_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ctr_col      <= 16'd16384;
			cfg_q.ctr_row      <= 16'd16384;
			cfg_q.pitch_x      <= 16'd5500;
			cfg_q.pitch_y      <= 16'd5500;
			cfg_q.focal_length <= 20'd25000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_X: cfg_q.ctr_col      <= cfg_data[COORD_W-1:0];
				REG_CENTER_Y: cfg_q.ctr_row      <= cfg_data[COORD_W-1:0];
				REG_PITCH_X:  cfg_q.pitch_x      <= cfg_data[COORD_W-1:0];
				REG_PITCH_Y:  cfg_q.pitch_y      <= cfg_data[COORD_W-1:0];
				REG_FOCAL:    cfg_q.focal_length <= cfg_data[FOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	logic      cmd_take;
	logic      vec_valid, prod_valid, sqrt_valid;
	los_pair_t vec_pair;
	sumsq_t    prod_sq;
	sincos_t   sqrt_sc;

	assign cmd_take = start && !busy;

	spad_vec #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_vec (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_take),
		.first_x  (first_x),
		.first_y  (first_y),
		.second_x (second_x),
		.second_y (second_y),
		.cfg      (cfg_q),
		.out_valid(vec_valid),
		.out_pair (vec_pair)
	);

	spad_prod u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vec_valid),
		.in_pair  (vec_pair),
		.out_valid(prod_valid),
		.out_sq   (prod_sq)
	);

	spad_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (prod_valid),
		.in_sq    (prod_sq),
		.out_valid(sqrt_valid),
		.out_sc   (sqrt_sc)
	);

	spad_cordic #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sqrt_valid),
		.in_sc    (sqrt_sc),
		.out_valid(done),
		.angle_deg(angle_deg)
	);

endmodule

// ===== rtl/core/spad_vec.sv =====
// Line-of-sight vectors from centroids, and their common normalizing shift.
module spad_vec import spad_pkg::*; #(
	parameter int COORD_FRAC_BITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [COORD_W-1:0] first_x,
	input  logic [COORD_W-1:0] first_y,
	input  logic [COORD_W-1:0] second_x,
	input  logic [COORD_W-1:0] second_y,
	input  cam_cfg_t           cfg,
	output logic               out_valid,
	output los_pair_t          out_pair
);

	localparam int X_W  = 2 * (COORD_W + 1);
	localparam int FM_W = 30;
	localparam int F_W  = FM_W + COORD_FRAC_BITS;
	localparam int MW   = (F_W > X_W - 1) ? F_W : X_W - 1;
	localparam int SH_W = $clog2(MW - NORM_BITS + 1);

	// Stage 1: offset and scale
	logic signed [COORD_W:0] dx0, dy0, dx1, dy1;
	logic signed [COORD_W:0] px, py;
	logic [FM_W-1:0]         f_mul;
	logic signed [X_W-1:0]   a0_s1, a1_s1, b0_s1, b1_s1;
	logic [F_W-1:0]          f_s1;
	logic                    v_s1;

	assign dx0   = $signed({1'b0, first_x})  - $signed({1'b0, cfg.ctr_col});
	assign dy0   = $signed({1'b0, first_y})  - $signed({1'b0, cfg.ctr_row});
	assign dx1   = $signed({1'b0, second_x}) - $signed({1'b0, cfg.ctr_col});
	assign dy1   = $signed({1'b0, second_y}) - $signed({1'b0, cfg.ctr_row});
	assign px    = $signed({1'b0, cfg.pitch_x});
	assign py    = $signed({1'b0, cfg.pitch_y});
	assign f_mul = FM_W'(cfg.focal_length) * FM_W'(1000);

	always_ff @(posedge clk) begin
		a0_s1 <= dx0 * px;
		a1_s1 <= dy0 * py;
		b0_s1 <= dx1 * px;
		b1_s1 <= dy1 * py;
		f_s1  <= F_W'(f_mul) << COORD_FRAC_BITS;
	end

	// Stage 2: shift that brings the largest magnitude below 2^30
	logic [MW-1:0]         m0, m1, m2, m3, mor;
	logic [SH_W:0]         blen_sh;
	logic [SH_W-1:0]       sh;
	logic signed [X_W-1:0] a0_s2, a1_s2, b0_s2, b1_s2;
	logic [F_W-1:0]        f_s2;
	logic [SH_W-1:0]       sh_s2;
	logic                  v_s2;

	assign m0  = MW'(a0_s1[X_W-1] ? -a0_s1 : a0_s1);
	assign m1  = MW'(a1_s1[X_W-1] ? -a1_s1 : a1_s1);
	assign m2  = MW'(b0_s1[X_W-1] ? -b0_s1 : b0_s1);
	assign m3  = MW'(b1_s1[X_W-1] ? -b1_s1 : b1_s1);
	assign mor = m0 | m1 | m2 | m3 | MW'(f_s1);

	// Bit length of the OR equals that of the maximum
	always_comb begin
		blen_sh = '0;
		for (int i = NORM_BITS; i < MW; i++) begin
			if (mor[i]) blen_sh = (SH_W + 1)'(i - NORM_BITS + 1);
		end
		sh = blen_sh[SH_W-1:0];
	end

	always_ff @(posedge clk) begin
		a0_s2 <= a0_s1;
		a1_s2 <= a1_s1;
		b0_s2 <= b0_s1;
		b1_s2 <= b1_s1;
		f_s2  <= f_s1;
		sh_s2 <= sh;
	end

	// Stage 3: floor shift of all components
	los_pair_t pair_s3;
	logic      v_s3;

	always_ff @(posedge clk) begin
		pair_s3.a0 <= VAL_W'(a0_s2 >>> sh_s2);
		pair_s3.a1 <= VAL_W'(a1_s2 >>> sh_s2);
		pair_s3.b0 <= VAL_W'(b0_s2 >>> sh_s2);
		pair_s3.b1 <= VAL_W'(b1_s2 >>> sh_s2);
		pair_s3.f  <= NORM_BITS'(f_s2 >> sh_s2);
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_pair  = pair_s3;

endmodule

// ===== rtl/core/spad_prod.sv =====
// Cross and dot products, second normalizing shift and sum of squares.
module spad_prod import spad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  los_pair_t in_pair,
	output logic      out_valid,
	output sumsq_t    out_sq
);

	localparam int P_W  = 2 * VAL_W;
	localparam int S_W  = 64;
	localparam int M_W  = S_W - 1;
	localparam int SH_W = $clog2(M_W - NORM_BITS + 1);
	localparam int SQ_W = 2 * MAG_W;

	// Stage 1: nine partial products
	logic signed [VAL_W-1:0] fs;
	logic signed [P_W-1:0]   a1f_s1, b1f_s1, b0f_s1, a0f_s1;
	logic signed [P_W-1:0]   a0b0_s1, a1b1_s1, a0b1_s1, a1b0_s1, ff_s1;
	logic                    v_s1;

	assign fs = $signed({1'b0, in_pair.f});

	always_ff @(posedge clk) begin
		a1f_s1  <= in_pair.a1 * fs;
		b1f_s1  <= in_pair.b1 * fs;
		b0f_s1  <= in_pair.b0 * fs;
		a0f_s1  <= in_pair.a0 * fs;
		a0b0_s1 <= in_pair.a0 * in_pair.b0;
		a1b1_s1 <= in_pair.a1 * in_pair.b1;
		a0b1_s1 <= in_pair.a0 * in_pair.b1;
		a1b0_s1 <= in_pair.a1 * in_pair.b0;
		ff_s1   <= fs * fs;
	end

	// Stage 2: cross components and dot product
	logic signed [S_W-1:0] c0_s2, c1_s2, c2_s2, dot_s2;
	logic                  v_s2;

	always_ff @(posedge clk) begin
		c0_s2  <= S_W'(a1f_s1) - S_W'(b1f_s1);
		c1_s2  <= S_W'(b0f_s1) - S_W'(a0f_s1);
		c2_s2  <= S_W'(a0b1_s1) - S_W'(a1b0_s1);
		dot_s2 <= S_W'(a0b0_s1) + S_W'(a1b1_s1) + S_W'(ff_s1);
	end

	// Stage 3: magnitudes and shift count
	logic [M_W-1:0]  cm0, cm1, cm2, dm, mor;
	logic [SH_W-1:0] sh;
	logic [M_W-1:0]  cm0_s3, cm1_s3, cm2_s3, dm_s3;
	logic [SH_W-1:0] sh_s3;
	logic            neg_s3;
	logic            v_s3;

	assign cm0 = M_W'(c0_s2[S_W-1] ? -c0_s2 : c0_s2);
	assign cm1 = M_W'(c1_s2[S_W-1] ? -c1_s2 : c1_s2);
	assign cm2 = M_W'(c2_s2[S_W-1] ? -c2_s2 : c2_s2);
	assign dm  = M_W'(dot_s2[S_W-1] ? -dot_s2 : dot_s2);
	assign mor = cm0 | cm1 | cm2 | dm;

	always_comb begin
		sh = '0;
		for (int i = NORM_BITS; i < M_W; i++) begin
			if (mor[i]) sh = SH_W'(i - NORM_BITS + 1);
		end
	end

	always_ff @(posedge clk) begin
		cm0_s3 <= cm0;
		cm1_s3 <= cm1;
		cm2_s3 <= cm2;
		dm_s3  <= dm;
		sh_s3  <= sh;
		neg_s3 <= dot_s2[S_W-1];
	end

	// Stage 4: truncating shift
	logic [MAG_W-1:0] cm0_s4, cm1_s4, cm2_s4, dm_s4;
	logic             neg_s4;
	logic             v_s4;

	always_ff @(posedge clk) begin
		cm0_s4 <= MAG_W'(cm0_s3 >> sh_s3);
		cm1_s4 <= MAG_W'(cm1_s3 >> sh_s3);
		cm2_s4 <= MAG_W'(cm2_s3 >> sh_s3);
		dm_s4  <= MAG_W'(dm_s3 >> sh_s3);
		neg_s4 <= neg_s3;
	end

	// Stage 5: squares
	logic [SQ_W-1:0]  sq0_s5, sq1_s5, sq2_s5;
	logic [MAG_W-1:0] dm_s5;
	logic             neg_s5;
	logic             v_s5;

	always_ff @(posedge clk) begin
		sq0_s5 <= cm0_s4 * cm0_s4;
		sq1_s5 <= cm1_s4 * cm1_s4;
		sq2_s5 <= cm2_s4 * cm2_s4;
		dm_s5  <= dm_s4;
		neg_s5 <= neg_s4;
	end

	// Stage 6: sum of squares
	sumsq_t sq_s6;
	logic   v_s6;

	always_ff @(posedge clk) begin
		sq_s6.sumsq   <= SUMSQ_W'(sq0_s5) + SUMSQ_W'(sq1_s5) + SUMSQ_W'(sq2_s5);
		sq_s6.dmag    <= dm_s5;
		sq_s6.dot_neg <= neg_s5;
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_sq    = sq_s6;

endmodule

// ===== rtl/core/spad_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module spad_sqrt import spad_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  sumsq_t  in_sq,
	output logic    out_valid,
	output sincos_t out_sc
);

	localparam int T_W = SUMSQ_W + 1;

	logic [SUMSQ_W-1:0] rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0]  root_s [ROOT_W+1];
	logic [MAG_W-1:0]   dmag_s [ROOT_W+1];
	logic [ROOT_W:0]    neg_s;
	logic [ROOT_W:0]    v_s;

	assign rem_s[0]  = in_sq.sumsq;
	assign root_s[0] = '0;
	assign dmag_s[0] = in_sq.dmag;
	assign neg_s[0]  = in_sq.dot_neg;
	assign v_s[0]    = in_valid;

	// Each stage tries the next lower root bit against the remainder
	for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
		localparam int B = ROOT_W - 1 - k;
		logic [T_W-1:0] trial;
		logic           take;

		assign trial = (T_W'(root_s[k]) << (B + 1)) | (T_W'(1) << (2 * B));
		assign take  = {1'b0, rem_s[k]} >= trial;

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= take ? SUMSQ_W'({1'b0, rem_s[k]} - trial) : rem_s[k];
			root_s[k+1] <= take ? (root_s[k] | (ROOT_W'(1) << B)) : root_s[k];
			dmag_s[k+1] <= dmag_s[k];
			neg_s[k+1]  <= neg_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end
	end

	assign out_valid      = v_s[ROOT_W];
	assign out_sc.s_term  = root_s[ROOT_W];
	assign out_sc.dmag    = dmag_s[ROOT_W];
	assign out_sc.dot_neg = neg_s[ROOT_W];

endmodule

// ===== rtl/core/spad_cordic.sv =====
// Pipelined CORDIC vectoring atan2 and conversion of half-turns to degrees.
module spad_cordic import spad_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  sincos_t            in_sc,
	output logic               out_valid,
	output logic [ANGLE_W-1:0] angle_deg
);

	localparam int H_W   = TURN_BITS + 1;
	localparam int DEG_W = H_W + 8;
	localparam int RSH   = TURN_BITS - ANGLE_FRAC_BITS;

	logic signed [XY_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  z_s [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0]  zero_s;
	logic [CORDIC_STEPS:0]  v_s;

	// Setup: pick quadrant from the sign of the dot product
	logic zero_in;
	assign zero_in = (in_sc.s_term == '0) && (in_sc.dmag == '0);

	always_ff @(posedge clk) begin
		if (in_sc.dot_neg) begin
			x_s[0] <= XY_W'(in_sc.s_term);
			y_s[0] <= XY_W'(in_sc.dmag);
			z_s[0] <= Z_W'(1) << (TURN_BITS - 1);
		end else begin
			x_s[0] <= XY_W'(in_sc.dmag);
			y_s[0] <= XY_W'(in_sc.s_term);
			z_s[0] <= '0;
		end
		zero_s[0] <= zero_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	// One rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_entry(i));
		logic signed [XY_W-1:0] xs, ys;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (!y_s[i][XY_W-1]) begin
				x_s[i+1] <= x_s[i] + ys;
				y_s[i+1] <= y_s[i] - xs;
				z_s[i+1] <= z_s[i] + ANG;
			end else begin
				x_s[i+1] <= x_s[i] - ys;
				y_s[i+1] <= y_s[i] + xs;
				z_s[i+1] <= z_s[i] - ANG;
			end
			zero_s[i+1] <= zero_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
	end

	// Clamp to [0, one half-turn]
	logic [H_W-1:0] half_s33;
	logic           zero_s33;
	logic           v_s33;
	logic signed [Z_W-1:0] z_fin;

	assign z_fin = z_s[CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (z_fin[Z_W-1]) begin
			half_s33 <= '0;
		end else if (z_fin > (Z_W'(1) << TURN_BITS)) begin
			half_s33 <= H_W'(1) << TURN_BITS;
		end else begin
			half_s33 <= H_W'(z_fin);
		end
		zero_s33 <= zero_s[CORDIC_STEPS];
	end

	// Scale to degrees with rounding
	logic [DEG_W-1:0]   deg_full;
	logic [ANGLE_W-1:0] angle_s34;
	logic               v_s34;

	assign deg_full = DEG_W'(half_s33) * DEG_W'(180) + (DEG_W'(1) << (RSH - 1));

	always_ff @(posedge clk) begin
		angle_s34 <= zero_s33 ? '0 : ANGLE_W'(deg_full >> RSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s33 <= 1'b0;
			v_s34 <= 1'b0;
		end else begin
			v_s33 <= v_s[CORDIC_STEPS];
			v_s34 <= v_s33;
		end
	end

	assign out_valid = v_s34;
	assign angle_deg = angle_s34;

endmodule

// ===== rtl/core/spad_checker.sv =====
// Port-level checks for the star pair angular distance block, with its bind.
module spad_checker import spad_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [ANGLE_W-1:0] angle_deg,
	input logic               cfg_valid,
	input logic               cfg_ready
);

	// Every result traces back to a command transaction a fixed latency earlier
	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching command");

	// Angle never exceeds 180 degrees
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle_deg <= 24'd11796480))
		else $error("angle beyond 180 degrees");

	// Pipeline never refuses a command
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("command refused");

	// Config writes always complete at once
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind star_pair_angular_distance spad_checker u_spad_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.angle_deg(angle_deg),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

// ===== verif/star_pair_angular_distance_tb.sv =====
// Self-checking testbench for the star pair angular distance block.
`timescale 1ns / 1ps

module star_pair_angular_distance_tb;
	import spad_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE       = LATENCY + 10;
	localparam int PHASE_ITEMS  = 190;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	// Angle predictor and store of expected angles
	class angle_scoreboard;
		longint unsigned atan_turns[CORDIC_STEPS];
		longint cx, cy, px, py, focal;
		bit [ANGLE_W-1:0] expected_angles[$];
		int errors;

		function new();
			longint unsigned pi_q60, r, q;
			cx = 16384; cy = 16384; px = 5500; py = 5500; focal = 25000;
			errors = 0;
			pi_q60 = 4 * (series_pow2(1) + series_third());
			atan_turns[0] = 64'd1 << (TURN_BITS - 2);
			for (int i = 1; i < CORDIC_STEPS; i++) begin
				r = series_pow2(i);
				q = 0;
				for (int k = 0; k < TURN_BITS; k++) begin
					r = r << 1;
					q = q << 1;
					if (r >= pi_q60) begin
						r = r - pi_q60;
						q = q | 1;
					end
				end
				atan_turns[i] = q;
			end
		endfunction

		// atan(2^-i) in Q60 by its power series
		function longint unsigned series_pow2(int i);
			longint unsigned acc, t;
			int sh;
			acc = 0;
			for (int k = 0; k < 64; k++) begin
				sh = i * (2 * k + 1);
				if (sh > 60) break;
				t = ((64'd1 << 60) >> sh) / longint'(2 * k + 1);
				if (k & 1) acc = acc - t;
				else acc = acc + t;
			end
			return acc;
		endfunction

		// atan(1/3) in Q60
		function longint unsigned series_third();
			longint unsigned acc, p, t;
			acc = 0;
			p = (64'd1 << 60) / 3;
			for (int k = 0; p != 0; k++) begin
				t = p / longint'(2 * k + 1);
				if (k & 1) acc = acc - t;
				else acc = acc + t;
				p = p / 9;
			end
			return acc;
		endfunction

		function longint unsigned magnitude(longint v);
			return (v < 0) ? longint'(-v) : v;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned root, bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= root + bitv) begin
					v = v - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			return root;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_CENTER_X: cx = data[COORD_W-1:0];
				REG_CENTER_Y: cy = data[COORD_W-1:0];
				REG_PITCH_X:  px = data[COORD_W-1:0];
				REG_PITCH_Y:  py = data[COORD_W-1:0];
				REG_FOCAL:    focal = data[FOCAL_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [ANGLE_W-1:0] separation(bit [15:0] fx, fy, sx, sy);
			longint a[3], b[3], c[3];
			longint dot, x, y, z, h, xs, ys;
			longint unsigned m, dmag, s_term, deg;
			longint unsigned cm[3];
			int sh;
			a[0] = (longint'(fx) - cx) * px;
			a[1] = (longint'(fy) - cy) * py;
			b[0] = (longint'(sx) - cx) * px;
			b[1] = (longint'(sy) - cy) * py;
			a[2] = focal * 1000 * 16;
			b[2] = a[2];
			// common scale so every component fits 30 bits
			m = 0;
			for (int i = 0; i < 3; i++) begin
				if (magnitude(a[i]) > m) m = magnitude(a[i]);
				if (magnitude(b[i]) > m) m = magnitude(b[i]);
			end
			sh = 0;
			while ((m >> sh) >= (64'd1 << 30)) sh++;
			for (int i = 0; i < 3; i++) begin
				a[i] = a[i] >>> sh;
				b[i] = b[i] >>> sh;
			end
			c[0] = a[1] * b[2] - a[2] * b[1];
			c[1] = a[2] * b[0] - a[0] * b[2];
			c[2] = a[0] * b[1] - a[1] * b[0];
			dot = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
			// second scale on cross and dot magnitudes
			dmag = magnitude(dot);
			m = dmag;
			for (int i = 0; i < 3; i++) begin
				cm[i] = magnitude(c[i]);
				if (cm[i] > m) m = cm[i];
			end
			sh = 0;
			while ((m >> sh) >= (64'd1 << 30)) sh++;
			for (int i = 0; i < 3; i++) cm[i] = cm[i] >> sh;
			dmag = dmag >> sh;
			s_term = int_sqrt(cm[0] * cm[0] + cm[1] * cm[1] + cm[2] * cm[2]);
			// degenerate vector gives zero
			if (s_term == 0 && dmag == 0) return '0;
			if (dot >= 0) begin
				x = dmag; y = s_term; z = 0;
			end else begin
				x = s_term; y = dmag; z = 64'sd1 <<< (TURN_BITS - 1);
			end
			// CORDIC vectoring
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys; y = y - xs; z = z + longint'(atan_turns[i]);
				end else begin
					x = x - ys; y = y + xs; z = z - longint'(atan_turns[i]);
				end
			end
			h = z;
			if (h < 0) h = 0;
			if (h > (64'sd1 <<< TURN_BITS)) h = 64'sd1 <<< TURN_BITS;
			deg = (longint'(h) * 180 + (64'd1 << (TURN_BITS - 1 - 16))) >> (TURN_BITS - 16);
			return deg[ANGLE_W-1:0];
		endfunction

		function void note_pair(bit [15:0] fx, fy, sx, sy);
			expected_angles.push_back(separation(fx, fy, sx, sy));
		endfunction

		function void check_angle(bit [ANGLE_W-1:0] got);
			bit [ANGLE_W-1:0] want;
			if (expected_angles.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d", $time, got);
				errors++;
				return;
			end
			want = expected_angles.pop_front();
			if (got !== want) begin
				$display("%0t: angle_deg expected %0d, actual %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [COORD_W-1:0]    first_x, first_y, second_x, second_y;
	logic                  done;
	logic [ANGLE_W-1:0]    angle_deg;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	angle_scoreboard sb;
	int idle_cycles;
	int burst_left;

	star_pair_angular_distance dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
		.done(done), .angle_deg(angle_deg),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Result check
	always @(posedge clk) begin
		if (arst_n && done) sb.check_angle(angle_deg);
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// One command transaction; start stays high for a following one
	task automatic send_pair(bit [15:0] fx, fy, sx, sy);
		start <= 1'b1;
		first_x <= fx; first_y <= fy; second_x <= sx; second_y <= sy;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_pair(fx, fy, sx, sy);
	endtask

	// Burst pacing: random gaps between bursts of random length
	task automatic paced_pair(bit [15:0] fx, fy, sx, sy);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
		end
		burst_left--;
		send_pair(fx, fy, sx, sy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_angles.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One config transaction; cfg_valid stays high for a following one
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic set_camera(logic [19:0] cx, cy, px, py, fl);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_PITCH_X, px);
		write_reg(REG_PITCH_Y, py);
		write_reg(REG_FOCAL, fl);
		cfg_valid <= 1'b0;
	endtask

	function automatic bit [15:0] near(longint ctr);
		return 16'(ctr + $urandom_range(0, 64) - 32);
	endfunction

	function automatic bit [15:0] extreme();
		case ($urandom_range(3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'(sb.cx);
			default: return 16'($urandom);
		endcase
	endfunction

	// Random pairs of several shapes
	task automatic random_pairs(int count);
		bit [15:0] fx, fy, sx, sy;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(4))
				0, 1: begin
					fx = 16'($urandom); fy = 16'($urandom);
					sx = 16'($urandom); sy = 16'($urandom);
				end
				2: begin
					fx = near(sb.cx); fy = near(sb.cy); sx = near(sb.cx); sy = near(sb.cy);
				end
				3: begin
					fx = 16'($urandom); fy = 16'($urandom); sx = fx; sy = fy;
					if ($urandom_range(1)) sx = sx + 16'd1;
				end
				default: begin
					fx = extreme(); fy = extreme(); sx = extreme(); sy = extreme();
				end
			endcase
			paced_pair(fx, fy, sx, sy);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		first_x = '0; first_y = '0; second_x = '0; second_y = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CENTER_X;
		cfg_data = '0;
		idle_cycles = 0;
		burst_left = 0;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at reset camera settings, back to back
		send_pair(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_pair(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
		send_pair(16'h4000, 16'h4000, 16'h4000, 16'h4000);
		send_pair(16'h4000, 16'h4000, 16'h4001, 16'h4000);
		send_pair(16'h4000, 16'h4000, 16'hFFFF, 16'hFFFF);
		send_pair(16'h1234, 16'hABCD, 16'h1234, 16'hABCD);
		send_pair(16'h0000, 16'h4000, 16'hFFFF, 16'h4000);
		send_pair(16'h4000, 16'h0000, 16'h4000, 16'hFFFF);
		send_pair(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
		drain();

		// Zero focal length: a star on center gives a zero vector
		set_camera(20'd16384, 20'd16384, 20'd5500, 20'd5500, 20'd0);
		send_pair(16'h4000, 16'h4000, 16'h4000, 16'h4000);
		send_pair(16'h4000, 16'h4000, 16'h9000, 16'h1000);
		send_pair(16'h0000, 16'h4000, 16'hFFFF, 16'h4000);
		send_pair(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
		random_pairs(PHASE_ITEMS);
		drain();

		// Spare register indexes are ignored
		write_reg(IDX_SPARE_LO, 20'hFFFFF);
		write_reg(IDX_SPARE_HI, 20'h00001);
		cfg_valid <= 1'b0;
		random_pairs(40);
		drain();

		// Reset camera values
		set_camera(20'd16384, 20'd16384, 20'd5500, 20'd5500, 20'd25000);
		random_pairs(PHASE_ITEMS);
		drain();

		// Zero center, unit pitch and unit focal length
		set_camera(20'd0, 20'd0, 20'd1, 20'd1, 20'd1);
		random_pairs(PHASE_ITEMS);
		drain();

		// Maximum center and pitch, focal length 1000000; wide writes masked to the register width
		set_camera(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'd1000000);
		random_pairs(PHASE_ITEMS);
		drain();

		// Full 20-bit focal length, zero horizontal pitch
		set_camera(20'd32768, 20'd100, 20'd0, 20'd65535, 20'hFFFFF);
		random_pairs(PHASE_ITEMS);
		drain();

		// Short lens, wide field
		set_camera(20'd32768, 20'd32768, 20'd65535, 20'd65535, 20'd1);
		random_pairs(PHASE_ITEMS);
		drain();

		// Random camera settings
		for (int p = 0; p < 4; p++) begin
			set_camera(20'($urandom), 20'($urandom), 20'($urandom_range(1, 65535)),
				20'($urandom_range(1, 65535)), 20'($urandom_range(1, 1000000)));
			random_pairs(PHASE_ITEMS);
			drain();
		end

		if (sb.errors == 0 && sb.expected_angles.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/spad_pkg.sv
rtl/core/spad_vec.sv
rtl/core/spad_prod.sv
rtl/core/spad_sqrt.sv
rtl/core/spad_cordic.sv
rtl/core/star_pair_angular_distance.sv
rtl/core/spad_checker.sv
verif/star_pair_angular_distance_tb.sv
